### design/flat_triangle_normal_emitter_macros.svh
// ----------------------------------------------------------------------------
// Flat triangle normal emitter assertion macros
// Shared concurrent assertion forms.
// ----------------------------------------------------------------------------
`ifndef FLAT_TRIANGLE_NORMAL_EMITTER_MACROS_SVH
`define FLAT_TRIANGLE_NORMAL_EMITTER_MACROS_SVH

// a condition implies a consequence in the next cycle
`define FTN_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");

// a condition always holds
`define FTN_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

### design/ftn_pkg.sv
// ----------------------------------------------------------------------------
// Flat triangle normal emitter package
// Widths, constants and payload types shared by the block.
// ----------------------------------------------------------------------------
package ftn_pkg;
   localparam int CoordWidth = 16;
   localparam int IndexWidth = 16;
   localparam int OneQ14 = 16384;

   typedef struct packed {
      logic                         start_mesh;
      logic signed [CoordWidth-1:0] a_x, a_y, a_z;
      logic signed [CoordWidth-1:0] b_x, b_y, b_z;
      logic signed [CoordWidth-1:0] c_x, c_y, c_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] pos_x, pos_y, pos_z;
      logic signed [15:0] norm_x, norm_y, norm_z;
      logic [15:0]        vertex_index;
      logic               degenerate;
      logic               last;
   } rsp_type;

   // classified triangle passed from front to back
   typedef struct packed {
      logic                         start_mesh;
      logic signed [CoordWidth-1:0] a_x, a_y, a_z;
      logic signed [CoordWidth-1:0] b_x, b_y, b_z;
      logic signed [CoordWidth-1:0] c_x, c_y, c_z;
      logic signed [15:0]           norm_x, norm_y, norm_z;
      logic                         degenerate;
   } tri_type;
endpackage

### design/ftn_req_if.sv
// ----------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one triangle.
// ----------------------------------------------------------------------------
interface ftn_req_if import ftn_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/ftn_rsp_if.sv
// ----------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one emitted vertex.
// ----------------------------------------------------------------------------
interface ftn_rsp_if import ftn_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/ftn_csr_if.sv
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready channel carrying the threshold register write data.
// ----------------------------------------------------------------------------
interface ftn_csr_if ();
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/flat_triangle_normal_emitter.sv
// ----------------------------------------------------------------------------
// Flat triangle normal emitter
// Triangle in, three flat-shaded vertices out.
// ----------------------------------------------------------------------------
// From its input transfer to its hand-off into the queue, a triangle passes
// through the front sequencer in order: edges, cross product and length test,
// normalizing shifts that bring the largest magnitude into [2^30, 2^31), the
// squares, a bitwise square root, three restoring divides (one per normal
// component) and the hand-off. Degenerate faces skip the normalization and
// go from the length test straight to the hand-off. The front takes the next
// triangle only once it is back in idle after its hand-off. The back emits
// one vertex a cycle while a triangle waits and the output is ready; a
// two-deep queue lets the front start the next triangle while vertices drain.
module flat_triangle_normal_emitter import ftn_pkg::*; (
   input logic clock,
   input logic reset,
   ftn_req_if.sink   req,
   ftn_rsp_if.source rsp,
   ftn_csr_if.sink   csr
);
   logic [15:0] thr_ff;
   logic        f_valid, f_ready, q_valid, q_ready;
   tri_type     f_data, q_data;

   // accept register writes at any time
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) thr_ff <= 16'd1;
      else if (csr.valid) thr_ff <= csr.data;
   end

   ftn_front u_front (.clock, .reset, .threshold(thr_ff),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data));

   ftn_queue u_queue (.clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data));

   ftn_back u_back (.clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data));
endmodule

### design/ftn_front.sv
// ----------------------------------------------------------------------------
// Front: face normal
// Edges, cross product, degeneracy test and normalization as a sequencer.
// ----------------------------------------------------------------------------
module ftn_front import ftn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] threshold,
   input  logic        in_valid,
   output logic        in_ready,
   input  req_type     in_data,
   output logic        out_valid,
   input  logic        out_ready,
   output tri_type     out_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_EDGE, S_MUL, S_CROSS, S_SUMSQ, S_SUM, S_TEST, S_NORM,
      S_SQ2, S_SQRT, S_DIV, S_DONE
   } state_type;

   localparam int EdgeShift = (CoordWidth > 16) ? CoordWidth - 16 : 0;
   localparam int Ew = CoordWidth + 1 - EdgeShift;
   localparam int ThrExp = 4 * (CoordWidth - 2) - 28 - 4 * EdgeShift;

   state_type          state_ff;
   req_type            req_ff;
   logic signed [Ew-1:0] u_ff [3];
   logic signed [Ew-1:0] w_ff [3];
   logic signed [2*Ew-1:0] pr_ff [6];
   logic [63:0]        mag_ff [3];
   logic [2:0]         neg_ff;
   logic [63:0]        sq_ff [3];
   logic [63:0]        s_ff;
   logic               degen_ff;
   logic [63:0]        rem_ff, root_ff, bit_ff;
   logic [1:0]         ci_ff;
   logic [47:0]        num_ff, quo_ff;
   logic [5:0]         dc_ff;
   logic [15:0]        nq_ff [3];
   logic [31:0]        t2_ff;
   logic [63:0]        peak;

   always_comb begin
      peak = mag_ff[0];
      if (mag_ff[1] > peak) peak = mag_ff[1];
      if (mag_ff[2] > peak) peak = mag_ff[2];
   end

   function automatic logic signed [Ew-1:0] edge_f(logic signed [CoordWidth-1:0] t,
                                                   logic signed [CoordWidth-1:0] f);
      logic signed [CoordWidth:0] d;
      d = {t[CoordWidth-1], t} - {f[CoordWidth-1], f};
      return Ew'(d >>> EdgeShift);
   endfunction

   // squares are only needed while every magnitude is below 2^31
   function automatic logic [61:0] square31(logic [30:0] x);
      return x * x;
   endfunction

   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_DONE);

   always_comb begin
      out_data = '0;
      out_data.start_mesh = req_ff.start_mesh;
      out_data.a_x = req_ff.a_x; out_data.a_y = req_ff.a_y; out_data.a_z = req_ff.a_z;
      out_data.b_x = req_ff.b_x; out_data.b_y = req_ff.b_y; out_data.b_z = req_ff.b_z;
      out_data.c_x = req_ff.c_x; out_data.c_y = req_ff.c_y; out_data.c_z = req_ff.c_z;
      out_data.norm_x = nq_ff[0];
      out_data.norm_y = nq_ff[1];
      out_data.norm_z = nq_ff[2];
      out_data.degenerate = degen_ff;
   end

   logic [63:0] thr_cmp;
   always_comb begin
      if (ThrExp >= 0) thr_cmp = 64'(t2_ff) << ((ThrExp >= 0) ? ThrExp : 0);
      else thr_cmp = 64'(t2_ff);
   end
   logic [63:0] s_cmp;
   assign s_cmp = (ThrExp >= 0) ? s_ff : (s_ff << ((ThrExp < 0) ? -ThrExp : 0));

   logic [63:0] trial;
   assign trial = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: if (in_valid) begin
               req_ff   <= in_data;
               t2_ff    <= 32'(threshold) * 32'(threshold);
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               u_ff[0] <= edge_f(req_ff.b_x, req_ff.a_x);
               u_ff[1] <= edge_f(req_ff.b_y, req_ff.a_y);
               u_ff[2] <= edge_f(req_ff.b_z, req_ff.a_z);
               w_ff[0] <= edge_f(req_ff.c_x, req_ff.a_x);
               w_ff[1] <= edge_f(req_ff.c_y, req_ff.a_y);
               w_ff[2] <= edge_f(req_ff.c_z, req_ff.a_z);
               state_ff <= S_MUL;
            end
            S_MUL: begin
               pr_ff[0] <= u_ff[1] * w_ff[2];
               pr_ff[1] <= u_ff[2] * w_ff[1];
               pr_ff[2] <= u_ff[2] * w_ff[0];
               pr_ff[3] <= u_ff[0] * w_ff[2];
               pr_ff[4] <= u_ff[0] * w_ff[1];
               pr_ff[5] <= u_ff[1] * w_ff[0];
               state_ff <= S_CROSS;
            end
            S_CROSS: begin
               for (int i = 0; i < 3; i++) begin
                  logic signed [63:0] n;
                  n = 64'(pr_ff[2*i]) - 64'(pr_ff[2*i+1]);
                  neg_ff[i] <= n[63];
                  mag_ff[i] <= n[63] ? 64'(-n) : 64'(n);
               end
               state_ff <= S_SUMSQ;
            end
            S_SUMSQ: begin
               // a magnitude of 2^31 or more skips the length test anyway
               for (int i = 0; i < 3; i++)
                  sq_ff[i] <= 64'(square31(mag_ff[i][30:0]));
               state_ff <= S_SUM;
            end
            S_SUM: begin
               s_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
               state_ff <= S_TEST;
            end
            S_TEST: begin
               if (peak >= 64'h8000_0000) degen_ff <= 1'b0;
               else degen_ff <= (peak == 0) || (s_cmp <= thr_cmp);
               if (peak != 0 && (peak >= 64'h8000_0000 || !(s_cmp <= thr_cmp))) begin
                  state_ff <= S_NORM;
               end else begin
                  nq_ff[0] <= '0; nq_ff[1] <= '0; nq_ff[2] <= 16'(OneQ14);
                  state_ff <= S_DONE;
               end
            end
            S_NORM: begin
               // shift one bit a cycle toward [2^30, 2^31)
               if (peak >= 64'h8000_0000) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] >> 1;
               end else if (peak < 64'h4000_0000) begin
                  for (int i = 0; i < 3; i++) mag_ff[i] <= mag_ff[i] << 1;
               end else begin
                  for (int i = 0; i < 3; i++)
                     sq_ff[i] <= 64'(square31(mag_ff[i][30:0]));
                  state_ff <= S_SQ2;
               end
            end
            S_SQ2: begin
               rem_ff   <= sq_ff[0] + sq_ff[1] + sq_ff[2];
               root_ff  <= '0;
               bit_ff   <= 64'h4000_0000_0000_0000;
               state_ff <= S_SQRT;
            end
            S_SQRT: begin
               if (bit_ff == 0) begin
                  ci_ff    <= '0;
                  num_ff   <= {mag_ff[0][33:0], 14'd0} + 48'(root_ff >> 1);
                  quo_ff   <= '0;
                  dc_ff    <= '0;
                  state_ff <= S_DIV;
               end else begin
                  if (rem_ff >= trial) begin
                     rem_ff  <= rem_ff - trial;
                     root_ff <= (root_ff >> 1) + bit_ff;
                  end else begin
                     root_ff <= root_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
            end
            S_DIV: begin
               // restoring divide, one quotient bit a cycle
               logic [47:0] rm;
               logic [47:0] q;
               rm = {quo_ff[47:0]} ;
               if (dc_ff == 6'd48) begin
                  logic [47:0] qq;
                  qq = num_ff;
                  if (qq > 48'(OneQ14)) qq = 48'(OneQ14);
                  nq_ff[ci_ff] <= neg_ff[ci_ff] ? 16'(-qq) : 16'(qq);
                  if (ci_ff == 2'd2) state_ff <= S_DONE;
                  else begin
                     ci_ff  <= ci_ff + 2'd1;
                     num_ff <= {mag_ff[ci_ff + 2'd1][33:0], 14'd0}
                               + 48'(root_ff >> 1);
                     quo_ff <= '0;
                     dc_ff  <= '0;
                  end
               end else begin
                  rm = {quo_ff[46:0], num_ff[47]};
                  q  = {num_ff[46:0], 1'b0};
                  if (64'(rm) >= root_ff) begin
                     rm = 48'(64'(rm) - root_ff);
                     q[0] = 1'b1;
                  end
                  quo_ff <= rm;
                  num_ff <= q;
                  dc_ff  <= dc_ff + 6'd1;
               end
            end
            S_DONE: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### design/ftn_queue.sv
// ----------------------------------------------------------------------------
// Triangle queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module ftn_queue import ftn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  tri_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output tri_type out_data
);
   tri_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) begin
            mem_ff[wp_ff] <= in_data;
            wp_ff <= ~wp_ff;
         end
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

### design/ftn_back.sv
// ----------------------------------------------------------------------------
// Back: vertex emitter
// Emit three vertices per triangle with the running index.
// ----------------------------------------------------------------------------
module ftn_back import ftn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  tri_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
`include "flat_triangle_normal_emitter_macros.svh"
   logic [1:0]            k_ff;
   logic [IndexWidth-1:0] cnt_ff;
   logic [IndexWidth-1:0] base;
   logic                  fire;

   assign out_valid = in_valid;
   assign fire      = in_valid && out_ready;
   assign in_ready  = fire && (k_ff == 2'd2);
   assign base      = (in_data.start_mesh ? '0 : cnt_ff) + IndexWidth'(k_ff);

   always_comb begin
      out_data = '0;
      unique case (k_ff)
         2'd0: begin
            out_data.pos_x = 16'(in_data.a_x); out_data.pos_y = 16'(in_data.a_y);
            out_data.pos_z = 16'(in_data.a_z);
         end
         2'd1: begin
            out_data.pos_x = 16'(in_data.b_x); out_data.pos_y = 16'(in_data.b_y);
            out_data.pos_z = 16'(in_data.b_z);
         end
         default: begin
            out_data.pos_x = 16'(in_data.c_x); out_data.pos_y = 16'(in_data.c_y);
            out_data.pos_z = 16'(in_data.c_z);
         end
      endcase
      out_data.norm_x = in_data.norm_x;
      out_data.norm_y = in_data.norm_y;
      out_data.norm_z = in_data.norm_z;
      out_data.vertex_index = 16'(base);
      out_data.degenerate = in_data.degenerate;
      out_data.last = (k_ff == 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0; cnt_ff <= '0;
      end else if (fire) begin
         if (k_ff == 2'd2) begin
            k_ff   <= '0;
            cnt_ff <= base + IndexWidth'(1);
         end else begin
            k_ff <= k_ff + 2'd1;
         end
      end
   end

   `FTN_ASSERT_ALWAYS(a_k_range, clock, reset, k_ff != 2'd3)
   `FTN_ASSERT_NEXT(a_last_wraps, clock, reset, fire && k_ff == 2'd2, k_ff == 2'd0)
   `FTN_ASSERT_NEXT(a_step, clock, reset, fire && k_ff != 2'd2, k_ff == $past(k_ff) + 2'd1)
endmodule
